/* rtl/core/assert_macros.svh */
// Assertion macros used by the line editor checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, held off during reset.
`define SLE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, held off during reset.
`define SLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/sle_pkg.sv */
// Package: constants, widths and controller/datapath link types for the line editor.
`default_nettype none
package sle_pkg;

    localparam int BYTE_W       = 8;
    localparam int CNT_W        = 6;
    localparam int LINE_CAP_DEF = 63;

    localparam logic [BYTE_W-1:0] CH_BS  = 8'd8;
    localparam logic [BYTE_W-1:0] CH_DEL = 8'd127;
    localparam logic [BYTE_W-1:0] CH_CR  = 8'd13;
    localparam logic [BYTE_W-1:0] CH_LF  = 8'd10;

    typedef struct packed {
        logic store;
        logic erase;
        logic start;
        logic rd;
        logic adv;
    } sle_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic is_eol;
        logic is_erase;
        logic last;
    } sle_status_t;

endpackage
`default_nettype wire

/* rtl/core/sle_if.sv */
// Stream interfaces: received byte channel and completed line channel.
`default_nettype none
interface sle_in_if
    import sle_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sle_out_if
    import sle_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] line_byte;
    logic              line_last;
    logic [CNT_W-1:0]  line_length;

    modport source (output valid, output line_byte, output line_last, output line_length,
                    input ready);
    modport sink   (input valid, input line_byte, input line_last, input line_length,
                    output ready);
endinterface
`default_nettype wire

/* rtl/core/serial_line_editor.sv */
// Line editor: one byte per beat in; a completed line is read out from a 1-port store.
// A byte that stores, erases or is ignored leaves the block idle and ready for the next byte.
// On a line end, the line is snapshot and the first character is read in ST_READ and goes valid
// in ST_SHOW; each further character is read the same way after the previous one is taken.
// No byte is accepted while a line is being read out.
// Reset clears the fill count and control state; store contents stay undefined until written.
`default_nettype none
module serial_line_editor
    import sle_pkg::*;
#(
    parameter int LINE_CAPACITY = LINE_CAP_DEF
)(
    input  wire logic clk,
    input  wire logic rst_n,
    sle_in_if.sink    rx_chan,
    sle_out_if.source line_chan
);

    sle_cmd_t    cmd;
    sle_status_t status;

    sle_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rx_chan.valid),
        .in_ready  (rx_chan.ready),
        .out_valid (line_chan.valid),
        .out_ready (line_chan.ready),
        .status    (status),
        .cmd       (cmd)
    );

    sle_datapath #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_byte     (rx_chan.rx_byte),
        .cmd         (cmd),
        .status      (status),
        .line_byte   (line_chan.line_byte),
        .line_length (line_chan.line_length)
    );

    assign line_chan.line_last = status.last;

endmodule
`default_nettype wire

/* rtl/core/sle_datapath.sv */
// Datapath: line store memory, fill count, read pointer and output data register.
`default_nettype none
module sle_datapath
    import sle_pkg::*;
#(
    parameter int LINE_CAPACITY = LINE_CAP_DEF
)(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [BYTE_W-1:0] rx_byte,
    input  wire sle_cmd_t          cmd,
    output sle_status_t            status,
    output logic [BYTE_W-1:0]      line_byte,
    output logic [CNT_W-1:0]       line_length
);

    localparam int IDX_W = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
    localparam logic [CNT_W-1:0] CAP = CNT_W'(LINE_CAPACITY);

    logic [BYTE_W-1:0] mem [LINE_CAPACITY];

    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            mem[fill_reg[IDX_W-1:0]] <= rx_byte;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= mem[ptr_reg[IDX_W-1:0]];
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        ptr_next  = ptr_reg;
        len_next  = len_reg;
        if (cmd.store)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else if (cmd.erase)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
        else if (cmd.start)
        begin
            // snapshot the line length and free the store for the next line
            len_next  = fill_reg;
            ptr_next  = '0;
            fill_next = '0;
        end
        if (cmd.adv)
        begin
            ptr_next = ptr_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            ptr_reg  <= '0;
            len_reg  <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            ptr_reg  <= ptr_next;
            len_reg  <= len_next;
        end
    end

    always_comb
    begin
        status.empty    = (fill_reg == '0);
        status.full     = (fill_reg >= CAP);
        status.is_eol   = (rx_byte == CH_CR) || (rx_byte == CH_LF);
        status.is_erase = (rx_byte == CH_BS) || (rx_byte == CH_DEL);
        status.last     = ((ptr_reg + CNT_W'(1)) == len_reg);
    end

    assign line_byte   = rd_data_reg;
    assign line_length = len_reg;

endmodule
`default_nettype wire

/* rtl/core/sle_ctrl.sv */
// Controller: classifies accepted beats and sequences the line readout.
`default_nettype none
module sle_ctrl
    import sle_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    input  wire sle_status_t status,
    output sle_cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_SHOW = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   in_fire;
    logic   out_fire;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_SHOW);
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (status.is_eol)
                    begin
                        if (!status.empty)
                        begin
                            cmd.start  = 1'b1;
                            state_next = ST_READ;
                        end
                    end
                    else if (status.is_erase)
                    begin
                        cmd.erase = !status.empty;
                    end
                    else
                    begin
                        cmd.store = !status.full;
                    end
                end
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_SHOW;
            end
            ST_SHOW:
            begin
                if (out_fire)
                begin
                    if (status.last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.adv    = 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/sle_checker.sv */
// Port-level checker for the line editor, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module sle_checker
    import sle_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [BYTE_W-1:0] line_byte,
    input wire logic              line_last,
    input wire logic [CNT_W-1:0]  line_length
);

    logic out_fire;
    assign out_fire = out_valid && out_ready;

    // input is held off for the whole readout of a line
    `SLE_ASSERT_NOW(a_no_overlap, out_valid, !in_ready, "input ready during line readout")
    // a readout beat always belongs to a non-empty line
    `SLE_ASSERT_NOW(a_len_nonzero, out_valid, line_length != '0, "zero line length on a beat")
    // more characters remain after a non-final beat
    `SLE_ASSERT_NEXT(a_more_follow, out_fire && !line_last, !in_ready,
        "input reopened before the final character")
    // final beat returns the block to accepting input
    `SLE_ASSERT_NEXT(a_back_idle, out_fire && line_last, in_ready && !out_valid,
        "not ready after the final character")
    // a stalled beat keeps its payload
    `SLE_ASSERT_NEXT(a_hold, out_valid && !out_ready,
        out_valid && $stable(line_byte) && $stable(line_last) && $stable(line_length),
        "stalled beat changed")

endmodule

bind serial_line_editor sle_checker u_sle_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (rx_chan.valid),
    .in_ready    (rx_chan.ready),
    .out_valid   (line_chan.valid),
    .out_ready   (line_chan.ready),
    .line_byte   (line_chan.line_byte),
    .line_last   (line_chan.line_last),
    .line_length (line_chan.line_length)
);
`default_nettype wire
